// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while reset is low.
`define CSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define CSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/csl_pkg.sv =====
// Shared types, codes and character tables of the C subset lexer.
package csl_pkg;

  localparam int MAX_IDENT_LEN = 32;

  localparam logic [30:0] NUM_MAX  = 31'h7FFF_FFFF;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_NUM     = 3'd0,
    KIND_CHUNK   = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_PUNCT   = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_END     = 3'd5
  } csl_kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_NUM   = 5'b00010,
    MODE_IDENT = 5'b00100,
    MODE_EQ    = 5'b01000,
    MODE_OR    = 5'b10000
  } csl_mode_t;

  // Punctuator codes.
  localparam logic [7:0] P_LPAREN = 8'd0;
  localparam logic [7:0] P_RPAREN = 8'd1;
  localparam logic [7:0] P_LBRACE = 8'd2;
  localparam logic [7:0] P_RBRACE = 8'd3;
  localparam logic [7:0] P_EQEQ   = 8'd4;
  localparam logic [7:0] P_ASSIGN = 8'd5;
  localparam logic [7:0] P_BAR    = 8'd6;
  localparam logic [7:0] P_OROR   = 8'd7;
  localparam logic [7:0] P_SEMI   = 8'd8;
  localparam logic [7:0] P_PLUS   = 8'd9;
  localparam logic [7:0] P_MINUS  = 8'd10;
  localparam logic [7:0] P_COMMA  = 8'd11;

  // Characters with a role of their own.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Keywords in code order, first character in the low byte.
  localparam int KW_COUNT = 6;
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h0000_6575_7274,  // true
    48'h0065_736C_6166,  // false
    48'h6E72_7574_6572,  // return
    48'h0000_0074_6E69,  // int
    48'h0000_0000_6669,  // if
    48'h0000_6573_6C65   // else
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4};

  // One result that stands alone (not part of a chunk run).
  typedef struct packed {
    logic        valid;
    csl_kind_t   kind;
    logic [7:0]  code;
    logic [30:0] num;
  } csl_tok_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } csl_punct_t;

  function automatic csl_punct_t single_punct(input logic [7:0] c);
    csl_punct_t r;
    r.hit  = 1'b1;
    r.code = P_LPAREN;
    unique case (c)
      CH_LPAREN: r.code = P_LPAREN;
      CH_RPAREN: r.code = P_RPAREN;
      CH_LBRACE: r.code = P_LBRACE;
      CH_RBRACE: r.code = P_RBRACE;
      CH_SEMI:   r.code = P_SEMI;
      CH_PLUS:   r.code = P_PLUS;
      CH_MINUS:  r.code = P_MINUS;
      CH_COMMA:  r.code = P_COMMA;
      default:   r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/csl_scan.sv =====
// Input register, scanner state and per-character tokenizing logic.
module csl_scan #(
  parameter int MAX_LEN = csl_pkg::MAX_IDENT_LEN,
  parameter int LEN_W   = $clog2(MAX_LEN + 1),
  parameter int CHUNKS  = (MAX_LEN + 7) / 8,
  parameter int CNT_W   = $clog2(CHUNKS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     end_of_text,
  output logic                     job_valid,
  input  logic                     job_ready,
  output csl_pkg::csl_tok_t        job_head,
  output csl_pkg::csl_tok_t        job_tail,
  output logic [CNT_W-1:0]         job_cnt,
  output logic [CHUNKS*64-1:0]     job_data,
  output logic [LEN_W-1:0]         job_len,
  output logic [15:0]              job_line
);

  localparam int IDX_W = $clog2(MAX_LEN);

  logic                in_full;
  logic [7:0]          in_char;
  logic                in_eot;
  logic                advance;

  csl_pkg::csl_mode_t  mode, mode_next;
  logic [30:0]         accum, accum_next;
  logic [LEN_W-1:0]    len, len_next;
  logic [15:0]         line, line_next;
  logic                halted, halted_next;
  logic [7:0]          ident_buf [MAX_LEN];

  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic                do_flush;
  logic                is_digit, is_alpha, is_ident_start, is_ident_char, is_space;
  logic [34:0]         prod;
  logic                kw_hit;
  logic [7:0]          kw_code;
  logic [LEN_W:0]      cnt_sum;
  logic [CHUNKS*64-1:0] masked;
  csl_pkg::csl_punct_t punct;

  assign in_stall = in_full && !job_ready;
  assign advance  = in_full && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_char <= char_code;
      in_eot  <= end_of_text;
    end
  end

  // Character classes.
  always_comb begin
    is_digit       = (in_char >= csl_pkg::CH_ZERO) && (in_char <= csl_pkg::CH_NINE);
    is_alpha       = ((in_char >= 8'h61) && (in_char <= 8'h7A)) ||
                     ((in_char >= 8'h41) && (in_char <= 8'h5A));
    is_ident_start = is_alpha || (in_char == csl_pkg::CH_UNDER);
    is_ident_char  = is_ident_start || is_digit;
    is_space       = (in_char == csl_pkg::CH_SPACE) ||
                     ((in_char >= csl_pkg::CH_TAB) && (in_char <= csl_pkg::CH_CR));
    punct          = csl_pkg::single_punct(in_char);
  end

  // accum * 10 + digit, kept wide enough to see the overflow.
  assign prod = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) +
                {27'd0, in_char - csl_pkg::CH_ZERO};

  // Keyword match over the first six buffered characters.
  always_comb begin
    kw_hit  = 1'b0;
    kw_code = 8'd0;
    for (int k = 0; k < csl_pkg::KW_COUNT; k++) begin
      logic eq;
      eq = (len == LEN_W'(csl_pkg::KW_LEN[k]));
      for (int i = 0; i < 6; i++) begin
        if (i < int'(csl_pkg::KW_LEN[k]) && ident_buf[i] != csl_pkg::KW_TEXT[k][i*8 +: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq && !kw_hit) begin
        kw_hit  = 1'b1;
        kw_code = 8'(k);
      end
    end
  end

  // Bytes past the identifier's length are stale and must read as zero.
  always_comb begin
    masked = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      masked[i*8 +: 8] = (LEN_W'(i) < len) ? ident_buf[i] : 8'd0;
    end
  end

  assign cnt_sum = {1'b0, len} + (LEN_W + 1)'(7);

  always_comb begin
    mode_next   = mode;
    accum_next  = accum;
    len_next    = len;
    line_next   = line;
    halted_next = halted;
    wr_en       = 1'b0;
    wr_idx      = len[IDX_W-1:0];
    do_flush    = 1'b0;
    job_head    = '0;
    job_tail    = '0;
    job_cnt     = '0;

    if (in_eot) begin
      do_flush      = !halted;
      job_tail.valid = 1'b1;
      job_tail.kind  = csl_pkg::KIND_END;
      mode_next     = csl_pkg::MODE_IDLE;
      accum_next    = '0;
      len_next      = '0;
      line_next     = 16'd1;
      halted_next   = 1'b0;
    end else if (halted) begin
      // Everything up to the end of text is dropped.
    end else if (mode == csl_pkg::MODE_EQ && in_char == csl_pkg::CH_EQ) begin
      job_head.valid = 1'b1;
      job_head.kind  = csl_pkg::KIND_PUNCT;
      job_head.code  = csl_pkg::P_EQEQ;
      mode_next      = csl_pkg::MODE_IDLE;
    end else if (mode == csl_pkg::MODE_OR && in_char == csl_pkg::CH_BAR) begin
      job_head.valid = 1'b1;
      job_head.kind  = csl_pkg::KIND_PUNCT;
      job_head.code  = csl_pkg::P_OROR;
      mode_next      = csl_pkg::MODE_IDLE;
    end else if (mode == csl_pkg::MODE_NUM && is_digit) begin
      accum_next = (prod > {4'd0, csl_pkg::NUM_MAX}) ? csl_pkg::NUM_MAX : prod[30:0];
    end else if (mode == csl_pkg::MODE_IDENT && is_ident_char) begin
      if (len >= LEN_W'(MAX_LEN)) begin
        job_tail.valid = 1'b1;
        job_tail.kind  = csl_pkg::KIND_ERROR;
        job_tail.code  = in_char;
        mode_next      = csl_pkg::MODE_IDLE;
        len_next       = '0;
        accum_next     = '0;
        halted_next    = 1'b1;
      end else begin
        wr_en    = 1'b1;
        len_next = len + LEN_W'(1);
      end
    end else begin
      do_flush  = 1'b1;
      mode_next = csl_pkg::MODE_IDLE;
      if (in_char == csl_pkg::CH_NL) begin
        if (line != csl_pkg::LINE_MAX) begin
          line_next = line + 16'd1;
        end
      end else if (is_space) begin
        // Skipped.
      end else if (is_digit) begin
        mode_next  = csl_pkg::MODE_NUM;
        accum_next = {23'd0, in_char - csl_pkg::CH_ZERO};
      end else if (is_ident_start) begin
        mode_next = csl_pkg::MODE_IDENT;
        wr_en     = 1'b1;
        wr_idx    = '0;
        len_next  = LEN_W'(1);
      end else if (in_char == csl_pkg::CH_EQ) begin
        mode_next = csl_pkg::MODE_EQ;
      end else if (in_char == csl_pkg::CH_BAR) begin
        mode_next = csl_pkg::MODE_OR;
      end else if (punct.hit) begin
        job_tail.valid = 1'b1;
        job_tail.kind  = csl_pkg::KIND_PUNCT;
        job_tail.code  = punct.code;
      end else begin
        job_tail.valid = 1'b1;
        job_tail.kind  = csl_pkg::KIND_ERROR;
        job_tail.code  = in_char;
        accum_next     = '0;
        len_next       = '0;
        halted_next    = 1'b1;
      end
    end

    // The pending token goes out ahead of anything this character adds.
    if (do_flush) begin
      unique case (mode)
        csl_pkg::MODE_NUM: begin
          job_head.valid = 1'b1;
          job_head.kind  = csl_pkg::KIND_NUM;
          job_head.num   = accum;
        end
        csl_pkg::MODE_IDENT: begin
          if (kw_hit) begin
            job_head.valid = 1'b1;
            job_head.kind  = csl_pkg::KIND_KEYWORD;
            job_head.code  = kw_code;
          end else begin
            job_cnt = CNT_W'(cnt_sum >> 3);
          end
        end
        csl_pkg::MODE_EQ: begin
          job_head.valid = 1'b1;
          job_head.kind  = csl_pkg::KIND_PUNCT;
          job_head.code  = csl_pkg::P_ASSIGN;
        end
        csl_pkg::MODE_OR: begin
          job_head.valid = 1'b1;
          job_head.kind  = csl_pkg::KIND_PUNCT;
          job_head.code  = csl_pkg::P_BAR;
        end
        csl_pkg::MODE_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign job_data  = masked;
  assign job_len   = len;
  assign job_line  = line;
  assign job_valid = in_full && (job_head.valid || job_tail.valid || (job_cnt != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= csl_pkg::MODE_IDLE;
      accum  <= '0;
      len    <= '0;
      line   <= 16'd1;
      halted <= 1'b0;
    end else if (advance) begin
      mode   <= mode_next;
      accum  <= accum_next;
      len    <= len_next;
      line   <= line_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      ident_buf[wr_idx] <= in_char;
    end
  end

endmodule

// ===== hw/rtl/csl_emit.sv =====
// Result queue slot and output register; sends one result per transfer.
module csl_emit #(
  parameter int MAX_LEN = csl_pkg::MAX_IDENT_LEN,
  parameter int LEN_W   = $clog2(MAX_LEN + 1),
  parameter int CHUNKS  = (MAX_LEN + 7) / 8,
  parameter int CNT_W   = $clog2(CHUNKS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_valid,
  output logic                     job_ready,
  input  csl_pkg::csl_tok_t        job_head,
  input  csl_pkg::csl_tok_t        job_tail,
  input  logic [CNT_W-1:0]         job_cnt,
  input  logic [CHUNKS*64-1:0]     job_data,
  input  logic [LEN_W-1:0]         job_len,
  input  logic [15:0]              job_line,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               token_kind,
  output logic [7:0]               token_code,
  output logic [30:0]              number_value,
  output logic [63:0]              text_chunk,
  output logic [LEN_W-1:0]         text_length,
  output logic                     chunk_last,
  output logic [15:0]              line_number
);

  csl_pkg::csl_tok_t     head, tail;
  logic [CNT_W-1:0]      cnt;
  logic [CHUNKS*64-1:0]  data;
  logic [LEN_W-1:0]      len;
  logic [15:0]           line;

  logic busy, out_free, emit, last_piece;

  assign busy     = head.valid || tail.valid || (cnt != '0);
  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && out_free;

  always_comb begin
    if (head.valid) begin
      last_piece = (cnt == '0) && !tail.valid;
    end else if (cnt != '0) begin
      last_piece = (cnt == CNT_W'(1)) && !tail.valid;
    end else begin
      last_piece = 1'b1;
    end
  end

  assign job_ready = !busy || (emit && last_piece);

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
      tail.valid <= 1'b0;
      cnt        <= '0;
    end else if (job_valid && job_ready) begin
      head <= job_head;
      tail <= job_tail;
      cnt  <= job_cnt;
      data <= job_data;
      len  <= job_len;
      line <= job_line;
    end else if (emit) begin
      if (head.valid) begin
        head.valid <= 1'b0;
      end else if (cnt != '0) begin
        cnt  <= cnt - CNT_W'(1);
        data <= data >> 64;
      end else begin
        tail.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      line_number <= line;
      if (head.valid || cnt == '0) begin
        token_kind   <= head.valid ? head.kind : tail.kind;
        token_code   <= head.valid ? head.code : tail.code;
        number_value <= head.valid ? head.num : tail.num;
        text_chunk   <= '0;
        text_length  <= '0;
        chunk_last   <= 1'b0;
      end else begin
        token_kind   <= csl_pkg::KIND_CHUNK;
        token_code   <= '0;
        number_value <= '0;
        text_chunk   <= data[63:0];
        text_length  <= len;
        chunk_last   <= (cnt == CNT_W'(1));
      end
    end
  end

endmodule

// ===== hw/rtl/c_subset_lexer.sv =====
// Top level of the C subset lexer: one character in, tokens out.
// Path: a character sits in the input register, its results in the queue slot, then out.
// Throughput: one character per cycle while each gives at most one result and out_stall
// is low; one that gives more (identifier chunk runs) holds the input until all are sent.
// Reset: synchronous rst empties all three stages, sets line 1 and leaves the scanner idle.
`include "assert_macros.svh"

module c_subset_lexer #(
  parameter int MAX_IDENT_LEN = csl_pkg::MAX_IDENT_LEN,
  parameter int LEN_W         = $clog2(MAX_IDENT_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  input  logic              end_of_text,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        token_kind,
  output logic [7:0]        token_code,
  output logic [30:0]       number_value,
  output logic [63:0]       text_chunk,
  output logic [LEN_W-1:0]  text_length,
  output logic              chunk_last,
  output logic [15:0]       line_number
);

  localparam int CHUNKS = (MAX_IDENT_LEN + 7) / 8;
  localparam int CNT_W  = $clog2(CHUNKS + 1);

  logic                    job_valid, job_ready;
  csl_pkg::csl_tok_t       job_head, job_tail;
  logic [CNT_W-1:0]        job_cnt;
  logic [CHUNKS*64-1:0]    job_data;
  logic [LEN_W-1:0]        job_len;
  logic [15:0]             job_line;

  csl_scan #(
    .MAX_LEN (MAX_IDENT_LEN),
    .LEN_W   (LEN_W),
    .CHUNKS  (CHUNKS),
    .CNT_W   (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job_head    (job_head),
    .job_tail    (job_tail),
    .job_cnt     (job_cnt),
    .job_data    (job_data),
    .job_len     (job_len),
    .job_line    (job_line)
  );

  csl_emit #(
    .MAX_LEN (MAX_IDENT_LEN),
    .LEN_W   (LEN_W),
    .CHUNKS  (CHUNKS),
    .CNT_W   (CNT_W)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job_head     (job_head),
    .job_tail     (job_tail),
    .job_cnt      (job_cnt),
    .job_data     (job_data),
    .job_len      (job_len),
    .job_line     (job_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_code   (token_code),
    .number_value (number_value),
    .text_chunk   (text_chunk),
    .text_length  (text_length),
    .chunk_last   (chunk_last),
    .line_number  (line_number)
  );

  `CSL_ASSERT(a_last_only_chunk, out_valid && chunk_last |-> token_kind == csl_pkg::KIND_CHUNK, "chunk_last set on a result that is not a chunk")
  `CSL_ASSERT(a_line_nonzero, out_valid |-> line_number != 16'd0, "result carries line zero")
  `CSL_ASSERT(a_chunk_len, out_valid && token_kind == csl_pkg::KIND_CHUNK |-> text_length != '0, "chunk result with zero length")
  `CSL_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid && !job_valid, "pipeline not empty after reset")

endmodule
